>>> hdl/pcbn_pkg.sv
`timescale 1ns / 1ps

package pcbn_pkg;

   // what a request asks the back end to do
   typedef enum logic {
      KIND_MEASURE   = 1'b0,
      KIND_TRANSFORM = 1'b1
   } kind_type;

   // head of the request queue as the back end sees it
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     final_point;
   } head_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEASURE,
      ST_CENTER,
      ST_SCALE,
      ST_DIVIDE,
      ST_DIFF,
      ST_MUL,
      ST_STORE,
      ST_RESULT
   } back_state_type;

   localparam int NUM_AXES      = 3;
   localparam int AXIS_W        = 2;
   localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_CNT_W   = 2;

endpackage

>>> hdl/point_cloud_box_normalizer_core.sv
`timescale 1ns / 1ps
// Bounding-box normalizer: maps a point cloud into the cube [-1, +1]^3.
// Request channel (req_*): tuser selects measure (0) or transform (1), tlast
// marks the last point of a pass, tdata carries x, y, z in signed fixed point.
// Measure requests grow a per-axis min/max box and return nothing; the measure
// request with tlast set closes the pass and latches the center and one
// uniform scale. Transform requests return (p - center) * scale, clamped to
// +/-1.0, on the response channel (rsp_*), with tlast copied from the request.
// Flow: a two-entry request queue feeds the sequencer. A transform works one
// axis at a time (difference, product, store) through one shared subtractor
// and multiplier, then loads the output register. Closing a pass runs the
// per-axis center step, then the bit-serial divider that forms the scale.
// Reset clears the box, center and scale to zero, so transforms before any
// closed pass return zero. When the receiver stalls the response register
// holds; the queue keeps taking requests until both entries are full.
module point_cloud_box_normalizer_core import pcbn_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int IN_DATA_W  = ((3*COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_DATA_W = ((3*(FRAC_BITS+2) + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // px, py, pz, zero pad
   input  logic                  req_tuser,   // action
   input  logic                  req_tlast,   // final_point
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // nx, ny, nz, zero pad
   output logic                  rsp_tlast    // end_of_run
);

   localparam int OW = FRAC_BITS + 2;

   head_ctrl_type                head_ctrl;
   logic [3*COORD_WIDTH-1:0]     head_point;
   logic                         head_pop;
   logic [3*OW-1:0]              rsp_data;

   pcbn_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_point  (req_tdata[3*COORD_WIDTH-1:0]),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .head_ctrl  (head_ctrl),
      .head_point (head_point),
      .head_pop   (head_pop)
   );

   pcbn_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_ctrl  (head_ctrl),
      .head_point (head_point),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = OUT_DATA_W'(rsp_data);

endmodule

>>> hdl/pcbn_front.sv
`timescale 1ns / 1ps

module pcbn_front import pcbn_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [3*COORD_WIDTH-1:0] req_point,
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output head_ctrl_type            head_ctrl,
   output logic [3*COORD_WIDTH-1:0] head_point,
   input  logic                     head_pop
);

   localparam int PW = 3*COORD_WIDTH;
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   logic [PW-1:0]          point_ff [QUEUE_DEPTH];
   kind_type               kind_ff  [QUEUE_DEPTH];
   logic                   last_ff  [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign req_tready = (count_ff != CNT_FULL);
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on entry: tuser picks measure or transform
   always_ff @(posedge clock) begin
      if (push) begin
         point_ff[wr_ptr_ff] <= req_point;
         kind_ff[wr_ptr_ff]  <= kind_type'(req_tuser);
         last_ff[wr_ptr_ff]  <= req_tlast;
      end
   end

   assign head_ctrl.valid       = (count_ff != '0);
   assign head_ctrl.kind        = kind_ff[rd_ptr_ff];
   assign head_ctrl.final_point = last_ff[rd_ptr_ff];
   assign head_point            = point_ff[rd_ptr_ff];

endmodule

>>> hdl/pcbn_div.sv
`timescale 1ns / 1ps

module pcbn_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [COORD_WIDTH-1:0]   divisor,
   output logic                     done,
   output logic [2*FRAC_BITS+1:0]   quotient
);

   // restoring division of 2^(2*FRAC_BITS+1) by divisor, one bit a cycle
   localparam int CW    = COORD_WIDTH;
   localparam int QW    = 2*FRAC_BITS + 2;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic [CNT_W-1:0] CNT_START = CNT_W'(QW);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [CW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [CW:0]      trial;
   logic             fits;
   logic             dividend_bit;

   // the dividend has a single one, in its top bit
   assign dividend_bit = (cnt_ff == CNT_START);
   assign trial        = {rem_ff, dividend_bit};
   assign fits         = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = '0;
         cnt_in = CNT_START;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
         quo_in  = {quo_ff[QW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/pcbn_back.sv
`timescale 1ns / 1ps

module pcbn_back import pcbn_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  head_ctrl_type                head_ctrl,
   input  logic [3*COORD_WIDTH-1:0]     head_point,
   output logic                         head_pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [3*(FRAC_BITS+2)-1:0]   rsp_data,
   output logic                         rsp_tlast
);

   localparam int CW = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int OW = F + 2;
   localparam int QW = 2*F + 2;
   localparam int PW = 4*F;
   localparam int MW = CW + 1 + 2*F;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   back_state_type state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;

   logic signed [CW-1:0] low_ff    [NUM_AXES];
   logic signed [CW-1:0] high_ff   [NUM_AXES];
   logic signed [CW-1:0] center_ff [NUM_AXES];
   logic signed [CW-1:0] pt_ff     [NUM_AXES];
   logic [OW-1:0]        res_ff    [NUM_AXES];
   logic [QW-1:0]        scale_ff;
   logic                 started_ff;
   logic                 fin_ff;
   logic [CW-1:0]        maxe_ff, maxe_in;
   logic [CW:0]          mag_ff, mag_in;
   logic                 neg_ff;
   logic [PW-1:0]        prod_ff, prod_in;
   logic                 sat_ff, sat_in;
   logic                 rsp_valid_ff;
   logic [3*OW-1:0]      rsp_data_ff;
   logic                 rsp_last_ff;

   // sequencer controls
   logic load_item, do_measure, do_center, do_scale_zero, div_start, load_scale;
   logic do_diff, do_mul, do_store, load_rsp;
   logic rsp_free;
   logic div_done;
   logic [QW-1:0] quotient;

   // per-axis datapath
   logic signed [CW:0] sum_hl, ext_hl, diff;
   logic [CW-1:0]      ext;
   logic [MW-1:0]      mag_ext;
   logic [2*F-1:0]     mag_lo;
   logic               mag_big;
   logic               sat_all;
   logic [F:0]         res_mag;
   logic [OW-1:0]      res_ext, res_in;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_ctrl.valid) begin
               state_in = (head_ctrl.kind == KIND_MEASURE) ? ST_MEASURE : ST_DIFF;
            end
         end
         ST_MEASURE: state_in = fin_ff ? ST_CENTER : ST_IDLE;
         ST_CENTER: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = (maxe_ff != '0) ? ST_DIVIDE : ST_IDLE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_STORE;
         ST_STORE:  state_in = (axis_ff == AXIS_LAST) ? ST_RESULT : ST_DIFF;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load_item     = 1'b0;
      do_measure    = 1'b0;
      do_center     = 1'b0;
      do_scale_zero = 1'b0;
      div_start     = 1'b0;
      load_scale    = 1'b0;
      do_diff       = 1'b0;
      do_mul        = 1'b0;
      do_store      = 1'b0;
      load_rsp      = 1'b0;
      axis_in       = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            load_item = head_ctrl.valid;
            axis_in   = AXIS_FIRST;
         end
         ST_MEASURE: begin
            do_measure = 1'b1;
            axis_in    = AXIS_FIRST;
         end
         ST_CENTER: begin
            do_center = 1'b1;
            axis_in   = axis_ff + 1'b1;
         end
         ST_SCALE: begin
            do_scale_zero = (maxe_ff == '0);
            div_start     = (maxe_ff != '0);
         end
         ST_DIVIDE: load_scale = div_done;
         ST_DIFF:   do_diff = 1'b1;
         ST_MUL:    do_mul = 1'b1;
         ST_STORE: begin
            do_store = 1'b1;
            axis_in  = axis_ff + 1'b1;
         end
         ST_RESULT: load_rsp = rsp_free;
         default: begin
         end
      endcase
   end

   assign head_pop = load_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_FIRST;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // box bookkeeping; the first point of a pass seeds the box
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         scale_ff   <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            low_ff[i]    <= '0;
            high_ff[i]   <= '0;
            center_ff[i] <= '0;
         end
      end else begin
         if (do_measure) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (!started_ff || (pt_ff[i] < low_ff[i])) begin
                  low_ff[i] <= pt_ff[i];
               end
               if (!started_ff || (pt_ff[i] > high_ff[i])) begin
                  high_ff[i] <= pt_ff[i];
               end
            end
            started_ff <= !fin_ff;
         end
         if (do_center) begin
            center_ff[axis_ff] <= sum_hl[CW:1];
         end
         if (do_scale_zero) begin
            scale_ff <= '0;
         end else if (load_scale) begin
            scale_ff <= quotient;
         end
      end
   end

   // floor of the midpoint, extent is never negative
   assign sum_hl = {high_ff[axis_ff][CW-1], high_ff[axis_ff]}
                 + {low_ff[axis_ff][CW-1], low_ff[axis_ff]};
   assign ext_hl = {high_ff[axis_ff][CW-1], high_ff[axis_ff]}
                 - {low_ff[axis_ff][CW-1], low_ff[axis_ff]};
   assign ext    = ext_hl[CW-1:0];

   always_comb begin
      maxe_in = maxe_ff;
      if (do_measure) begin
         maxe_in = '0;
      end else if (do_center && (ext > maxe_ff)) begin
         maxe_in = ext;
      end
   end

   pcbn_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (maxe_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // transform: difference, product, clamp, one axis at a time
   assign diff   = {pt_ff[axis_ff][CW-1], pt_ff[axis_ff]}
                 - {center_ff[axis_ff][CW-1], center_ff[axis_ff]};
   assign mag_in = diff[CW] ? (CW+1)'(-diff) : diff;

   assign mag_ext = {{(2*F){1'b0}}, mag_ff};
   assign mag_big = |mag_ext[MW-1:2*F];
   assign mag_lo  = mag_ext[2*F-1:0];
   assign sat_in  = ((mag_ff != '0) && (|scale_ff[QW-1:2*F]))
                 || ((scale_ff != '0) && mag_big);
   assign prod_in = {{(2*F){1'b0}}, mag_lo} * {{(2*F){1'b0}}, scale_ff[2*F-1:0]};

   assign sat_all = sat_ff || (|prod_ff[PW-1:2*F]);
   assign res_mag = sat_all ? ONE : {1'b0, prod_ff[2*F-1:F]};
   assign res_ext = {1'b0, res_mag};
   assign res_in  = neg_ff ? OW'(-res_ext) : res_ext;

   always_ff @(posedge clock) begin
      maxe_ff <= maxe_in;
      if (load_item) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            pt_ff[i] <= head_point[i*CW +: CW];
         end
         fin_ff <= head_ctrl.final_point;
      end
      if (do_diff) begin
         mag_ff <= mag_in;
         neg_ff <= diff[CW];
      end
      if (do_mul) begin
         prod_ff <= prod_in;
         sat_ff  <= sat_in;
      end
      if (do_store) begin
         res_ff[axis_ff] <= res_in;
      end
   end

   // output register, holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
         rsp_last_ff <= fin_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/pcbn_checker.sv
`timescale 1ns / 1ps

module pcbn_checker #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int IN_DATA_W  = ((3*COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_DATA_W = ((3*(FRAC_BITS+2) + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [IN_DATA_W-1:0]  req_tdata,
   input logic                  req_tuser,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   localparam int OW = FRAC_BITS + 2;
   localparam logic signed [OW-1:0] POS_ONE = OW'(1 << FRAC_BITS);
   localparam logic signed [OW-1:0] NEG_ONE = OW'(-(1 << FRAC_BITS));

   logic signed [OW-1:0] nx, ny, nz;

   assign nx = rsp_tdata[OW-1:0];
   assign ny = rsp_tdata[2*OW-1:OW];
   assign nz = rsp_tdata[3*OW-1:2*OW];

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (nx <= POS_ONE) && (nx >= NEG_ONE) && (ny <= POS_ONE)
                     && (ny >= NEG_ONE) && (nz <= POS_ONE) && (nz >= NEG_ONE))
      else $error("normalized coordinate beyond one");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (3*OW)) == '0))
      else $error("response pad bits not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // the queue is not full right after reset; two requests fill it only if the first was still waiting
   a_no_early_full: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("request queue full right after reset");

endmodule

bind point_cloud_box_normalizer_core pcbn_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .FRAC_BITS   (FRAC_BITS)
) u_pcbn_checker (.*);
